// File: rtl/sthc_pkg.sv
// ----------------------------------------------------------------------------
// Temperature and humidity compensation package
// Shared types, register indexes, stage numbers and arithmetic constants.
// ----------------------------------------------------------------------------
package sthc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 40;
   localparam int RAW_TEMP_W  = 20;
   localparam int RAW_HUM_W   = 16;
   localparam int TEMP_W      = 16;
   localparam int HUM_W       = 17;

   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_CAL_ONE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_CAL_TWO   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_CAL_THREE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HUM_CAL_ONE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_HUM_CAL_TWO    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_HUM_CAL_BYTES  = 3'd5;

   // Pipeline stage numbers. Each divider by 100 occupies three stages.
   localparam int DIV_STAGES  = 3;
   localparam int ST_TC       = 4;
   localparam int ST_MUL_H    = 5;
   localparam int ST_DIV1     = 6;
   localparam int ST_V1       = ST_DIV1 + DIV_STAGES;
   localparam int ST_DIV2     = ST_V1 + 1;
   localparam int ST_MIX      = ST_DIV2 + DIV_STAGES;
   localparam int ST_V2       = ST_MIX + 1;
   localparam int ST_V3       = ST_V2 + 1;
   localparam int ST_SQ       = ST_V3 + 1;
   localparam int ST_V6       = ST_SQ + 1;
   localparam int ST_SUM      = ST_V6 + 1;
   localparam int ST_SCALE    = ST_SUM + 1;
   localparam int ST_OUT      = ST_SCALE + 1;
   localparam int NUM_STAGES  = ST_OUT + 1;

   // Reciprocal of 100: exact quotient for every 32-bit unsigned dividend.
   localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
   localparam int          DIV100_SHIFT = 37;
   localparam int          QUOT_W       = 26;

   localparam logic signed [31:0] TEMP_ROUND = 32'sd128;
   localparam logic signed [31:0] HUM_OFFSET = 32'sd16384;
   localparam logic signed [31:0] HUM_SCALE  = 32'sd1000;
   localparam logic signed [31:0] HUM_MAX    = 32'sd100000;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [7:0]  t3;
      logic [11:0] h1;
      logic [11:0] h2;
      logic [7:0]  h3;
      logic [7:0]  h4;
      logic [7:0]  h5;
      logic [7:0]  h6;
      logic [7:0]  h7;
   } cal_type;

endpackage

// File: rtl/sthc_div100.sv
// ----------------------------------------------------------------------------
// Signed divide by 100
// Three-stage divider that truncates toward zero: magnitude, reciprocal
// multiply, then sign restore.
// ----------------------------------------------------------------------------
module sthc_div100 (
   input  logic                                clock,
   input  logic [sthc_pkg::DIV_STAGES-1:0]     load,
   input  logic signed [31:0]                  dividend,
   output logic signed [31:0]                  quotient
);
   import sthc_pkg::*;

   logic                     neg_a_ff;
   logic                     neg_b_ff;
   logic [31:0]              mag_in;
   logic [31:0]              mag_ff;
   logic [63:0]              prod;
   logic [QUOT_W-1:0]        quot_ff;
   logic [31:0]              quot_wide;
   logic signed [31:0]       quotient_in;
   logic signed [31:0]       quotient_ff;

   always_comb begin
      mag_in      = dividend[31] ? (32'd0 - dividend) : dividend;
      prod        = 64'(mag_ff) * 64'(DIV100_MAGIC);
      quot_wide   = {{(32-QUOT_W){1'b0}}, quot_ff};
      quotient_in = neg_b_ff ? (32'd0 - quot_wide) : quot_wide;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         neg_a_ff <= dividend[31];
         mag_ff   <= mag_in;
      end
      if (load[1]) begin
         neg_b_ff <= neg_a_ff;
         quot_ff  <= prod[DIV100_SHIFT +: QUOT_W];
      end
      if (load[2]) begin
         quotient_ff <= quotient_in;
      end
   end

   assign quotient = quotient_ff;

endmodule

// File: rtl/sthc_temp.sv
// ----------------------------------------------------------------------------
// Temperature compensation stages
// Computes the compensated temperature over the first five pipeline stages
// and carries the raw humidity reading alongside.
// ----------------------------------------------------------------------------
module sthc_temp (
   input  logic                                 clock,
   input  logic [sthc_pkg::ST_TC:0]             load,
   input  sthc_pkg::cal_type                    cal,
   input  logic [sthc_pkg::RAW_TEMP_W-1:0]      raw_temperature,
   input  logic [sthc_pkg::RAW_HUM_W-1:0]       raw_humidity,
   output logic signed [sthc_pkg::TEMP_W-1:0]   tc,
   output logic [sthc_pkg::RAW_HUM_W-1:0]       hum_raw
);
   import sthc_pkg::*;

   logic signed [17:0]       a_in;
   logic signed [17:0]       a_ff;
   logic signed [16:0]       a_half;
   logic signed [31:0]       p1_in;
   logic signed [31:0]       p1_ff;
   logic signed [31:0]       sq_in;
   logic signed [31:0]       sq_ff;
   logic signed [20:0]       b_ff;
   logic signed [19:0]       sq_shr;
   logic signed [31:0]       t3_scaled;
   logic signed [31:0]       p2_in;
   logic signed [31:0]       p2_ff;
   logic signed [21:0]       fine_in;
   logic signed [21:0]       fine_ff;
   logic signed [31:0]       fine_x5;
   logic signed [TEMP_W-1:0] tc_ff;
   logic [RAW_HUM_W-1:0]     hraw_ff [0:ST_TC];

   always_comb begin
      a_in      = $signed({1'b0, raw_temperature[RAW_TEMP_W-1:3]})
                - $signed({1'b0, cal.t1, 1'b0});
      a_half    = a_ff[17:1];
      p1_in     = 32'(a_ff) * 32'($signed(cal.t2));
      sq_in     = 32'(a_half) * 32'(a_half);
      sq_shr    = sq_ff[31:12];
      t3_scaled = 32'($signed(cal.t3)) <<< 4;
      p2_in     = 32'(sq_shr) * t3_scaled;
      fine_in   = 22'(b_ff) + 22'($signed(p2_ff[31:14]));
      fine_x5   = 32'(fine_ff) + (32'(fine_ff) <<< 2) + TEMP_ROUND;
   end

   // The fine value stays within +/-1179648, so the result fits 16 bits signed.
   always_ff @(posedge clock) begin
      if (load[0]) begin
         a_ff       <= a_in;
         hraw_ff[0] <= raw_humidity;
      end
      if (load[1]) begin
         p1_ff <= p1_in;
         sq_ff <= sq_in;
      end
      if (load[2]) begin
         b_ff  <= p1_ff[31:11];
         p2_ff <= p2_in;
      end
      if (load[3]) begin
         fine_ff <= fine_in;
      end
      if (load[ST_TC]) begin
         tc_ff <= fine_x5[23:8];
      end
      for (int k = 1; k <= ST_TC; k++) begin
         if (load[k]) begin
            hraw_ff[k] <= hraw_ff[k-1];
         end
      end
   end

   assign tc      = tc_ff;
   assign hum_raw = hraw_ff[ST_TC];

endmodule

// File: rtl/sthc_hum.sv
// ----------------------------------------------------------------------------
// Humidity compensation stages
// Evaluates the humidity formula from the compensated temperature, one
// multiplication per stage, with two rows of dividers by 100.
// ----------------------------------------------------------------------------
module sthc_hum (
   input  logic                                      clock,
   input  logic [sthc_pkg::ST_SCALE:sthc_pkg::ST_MUL_H] load,
   input  sthc_pkg::cal_type                         cal,
   input  logic signed [sthc_pkg::TEMP_W-1:0]        tc,
   input  logic [sthc_pkg::RAW_HUM_W-1:0]            hum_raw,
   output logic signed [sthc_pkg::TEMP_W-1:0]        tc_out,
   output logic signed [31:0]                        hum_scaled
);
   import sthc_pkg::*;

   logic signed [TEMP_W-1:0] tc_ff   [ST_MUL_H:ST_SCALE];
   logic [RAW_HUM_W-1:0]     hraw_ff [ST_MUL_H:ST_V1-1];
   logic signed [31:0]       m3_ff;
   logic signed [31:0]       m4_ff;
   logic signed [31:0]       m5_ff;
   logic signed [31:0]       m7_ff;
   logic signed [31:0]       d3;
   logic signed [31:0]       d4;
   logic signed [31:0]       d5;
   logic signed [31:0]       d7;
   logic signed [31:0]       e_quot;
   logic signed [17:0]       v1_in;
   logic signed [17:0]       v1_ff   [ST_V1:ST_V3-1];
   logic signed [31:0]       q_in;
   logic signed [31:0]       q_ff;
   logic signed [31:0]       q_shr;
   logic signed [31:0]       d4_ff   [ST_V1:ST_MIX-1];
   logic signed [31:0]       d7_ff   [ST_V1:ST_MIX-1];
   logic signed [31:0]       s_in;
   logic signed [31:0]       s_ff;
   logic signed [31:0]       v4_in;
   logic signed [31:0]       v4_ff   [ST_MIX:ST_V6-1];
   logic signed [31:0]       v2m_in;
   logic signed [31:0]       v2m_ff;
   logic signed [31:0]       v3_in;
   logic signed [31:0]       v3_ff   [ST_V3:ST_SUM-1];
   logic signed [31:0]       v3_shr;
   logic signed [31:0]       sq_in;
   logic signed [31:0]       sq_ff;
   logic signed [31:0]       v6m_in;
   logic signed [31:0]       v6m_ff;
   logic signed [31:0]       sum_in;
   logic signed [31:0]       sum_ff;
   logic signed [31:0]       hm_in;
   logic signed [31:0]       hm_ff;

   sthc_div100 u_div_h3 (
      .clock    (clock),
      .load     (load[ST_DIV1+DIV_STAGES-1:ST_DIV1]),
      .dividend (m3_ff),
      .quotient (d3)
   );

   sthc_div100 u_div_h4 (
      .clock    (clock),
      .load     (load[ST_DIV1+DIV_STAGES-1:ST_DIV1]),
      .dividend (m4_ff),
      .quotient (d4)
   );

   sthc_div100 u_div_h5 (
      .clock    (clock),
      .load     (load[ST_DIV1+DIV_STAGES-1:ST_DIV1]),
      .dividend (m5_ff),
      .quotient (d5)
   );

   sthc_div100 u_div_h7 (
      .clock    (clock),
      .load     (load[ST_DIV1+DIV_STAGES-1:ST_DIV1]),
      .dividend (m7_ff),
      .quotient (d7)
   );

   sthc_div100 u_div_quad (
      .clock    (clock),
      .load     (load[ST_DIV2+DIV_STAGES-1:ST_DIV2]),
      .dividend (q_shr),
      .quotient (e_quot)
   );

   always_comb begin
      v1_in  = $signed({2'b00, hraw_ff[ST_V1-1]})
             - $signed({2'b00, cal.h1, 4'b0000})
             - 18'(d3 >>> 1);
      q_in   = 32'(tc_ff[ST_V1-1]) * d5;
      q_shr  = q_ff >>> 6;
      s_in   = d4_ff[ST_MIX-1] + e_quot + HUM_OFFSET;
      v4_in  = ($signed({17'd0, cal.h6, 7'd0}) + d7_ff[ST_MIX-1]) >>> 4;
      v2m_in = $signed({20'd0, cal.h2}) * s_ff;
      v3_in  = 32'(v1_ff[ST_V3-1]) * (v2m_ff >>> 10);
      v3_shr = v3_ff[ST_SQ-1] >>> 14;
      sq_in  = v3_shr * v3_shr;
      v6m_in = v4_ff[ST_V6-1] * (sq_ff >>> 10);
      sum_in = v3_ff[ST_SUM-1] + (v6m_ff >>> 1);
      hm_in  = (sum_ff >>> 10) * HUM_SCALE;
   end

   always_ff @(posedge clock) begin
      if (load[ST_MUL_H]) begin
         tc_ff[ST_MUL_H]   <= tc;
         hraw_ff[ST_MUL_H] <= hum_raw;
         m3_ff             <= 32'(tc) * 32'($signed(cal.h3));
         m4_ff             <= 32'(tc) * 32'($signed(cal.h4));
         m5_ff             <= 32'(tc) * 32'($signed(cal.h5));
         m7_ff             <= 32'(tc) * 32'($signed(cal.h7));
      end
      if (load[ST_V1]) begin
         v1_ff[ST_V1] <= v1_in;
         q_ff         <= q_in;
         d4_ff[ST_V1] <= d4;
         d7_ff[ST_V1] <= d7;
      end
      if (load[ST_MIX]) begin
         s_ff          <= s_in;
         v4_ff[ST_MIX] <= v4_in;
      end
      if (load[ST_V2]) begin
         v2m_ff <= v2m_in;
      end
      if (load[ST_V3]) begin
         v3_ff[ST_V3] <= v3_in;
      end
      if (load[ST_SQ]) begin
         sq_ff <= sq_in;
      end
      if (load[ST_V6]) begin
         v6m_ff <= v6m_in;
      end
      if (load[ST_SUM]) begin
         sum_ff <= sum_in;
      end
      if (load[ST_SCALE]) begin
         hm_ff <= hm_in;
      end
      for (int k = ST_MUL_H + 1; k <= ST_SCALE; k++) begin
         if (load[k]) begin
            tc_ff[k] <= tc_ff[k-1];
         end
      end
      for (int k = ST_MUL_H + 1; k < ST_V1; k++) begin
         if (load[k]) begin
            hraw_ff[k] <= hraw_ff[k-1];
         end
      end
      for (int k = ST_V1 + 1; k < ST_V3; k++) begin
         if (load[k]) begin
            v1_ff[k] <= v1_ff[k-1];
         end
      end
      for (int k = ST_V1 + 1; k < ST_MIX; k++) begin
         if (load[k]) begin
            d4_ff[k] <= d4_ff[k-1];
            d7_ff[k] <= d7_ff[k-1];
         end
      end
      for (int k = ST_MIX + 1; k < ST_V6; k++) begin
         if (load[k]) begin
            v4_ff[k] <= v4_ff[k-1];
         end
      end
      for (int k = ST_V3 + 1; k < ST_SUM; k++) begin
         if (load[k]) begin
            v3_ff[k] <= v3_ff[k-1];
         end
      end
   end

   assign tc_out     = tc_ff[ST_SCALE];
   assign hum_scaled = hm_ff;

endmodule

// File: rtl/sensor_temp_humidity_compensation_core.sv
// ----------------------------------------------------------------------------
// Sensor temperature and humidity compensation core
// Turns a raw 20-bit temperature and 16-bit humidity reading into the
// temperature in 0.01 degC and the relative humidity in 0.001 %RH, using the
// integer compensation formulas with 32-bit wrapping intermediates. The core
// is a 21-stage pipeline: it takes one transfer per clock while nothing
// stalls. No stage chains more than one multiplication, and each division
// by 100 is a three-stage reciprocal multiplier, which together set the
// depth. A stall on the result side holds only the stages that are full, so
// empty slots close up and requests keep flowing until the pipeline is full.
// The calibration registers reset to zero and are written through the csr_
// port; the user must write them only while no request is in flight, as the
// core does not enforce it. With any calibration the compensated temperature
// stays within +/-23040, and humidity is clamped to 0..100000.
// ----------------------------------------------------------------------------
module sensor_temp_humidity_compensation_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [sthc_pkg::RAW_TEMP_W-1:0]        req_raw_temperature,
   input  logic [sthc_pkg::RAW_HUM_W-1:0]         req_raw_humidity,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [sthc_pkg::TEMP_W-1:0]     rsp_temperature_centi,
   output logic [sthc_pkg::HUM_W-1:0]             rsp_humidity_milli,
   input  logic                                   csr_write_en,
   input  logic [sthc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sthc_pkg::CSR_DATA_W-1:0]        csr_data
);
   import sthc_pkg::*;

   cal_type                  cal_in;
   cal_type                  cal_ff;
   logic [NUM_STAGES-1:0]    vld_in;
   logic [NUM_STAGES-1:0]    vld_ff;
   logic [NUM_STAGES-1:0]    stage_ready;
   logic [NUM_STAGES-1:0]    low_mask;
   logic signed [TEMP_W-1:0] tc;
   logic [RAW_HUM_W-1:0]     hum_raw;
   logic signed [TEMP_W-1:0] tc_late;
   logic signed [31:0]       hum_scaled;
   logic signed [31:0]       hum_shr;
   logic [HUM_W-1:0]         hum_in;
   logic [HUM_W-1:0]         hum_ff;
   logic signed [TEMP_W-1:0] temp_ff;

   always_comb begin
      cal_in = cal_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_TEMP_CAL_ONE:   cal_in.t1 = csr_data[15:0];
            REG_TEMP_CAL_TWO:   cal_in.t2 = csr_data[15:0];
            REG_TEMP_CAL_THREE: cal_in.t3 = csr_data[7:0];
            REG_HUM_CAL_ONE:    cal_in.h1 = csr_data[11:0];
            REG_HUM_CAL_TWO:    cal_in.h2 = csr_data[11:0];
            REG_HUM_CAL_BYTES: begin
               cal_in.h3 = csr_data[7:0];
               cal_in.h4 = csr_data[15:8];
               cal_in.h5 = csr_data[23:16];
               cal_in.h6 = csr_data[31:24];
               cal_in.h7 = csr_data[39:32];
            end
            default: ;
         endcase
      end
   end

   // A stage must hold only when it and every stage after it are full and the
   // result is stalled.
   always_comb begin
      low_mask    = '0;
      stage_ready = '0;
      for (int k = 0; k < NUM_STAGES; k++) begin
         low_mask       = NUM_STAGES'((64'd1 << k) - 64'd1);
         stage_ready[k] = !(rsp_stall && (&(vld_ff | low_mask)));
      end
      vld_in[0] = stage_ready[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = stage_ready[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
         vld_ff <= '0;
      end else begin
         cal_ff <= cal_in;
         vld_ff <= vld_in;
      end
   end

   sthc_temp u_temp (
      .clock           (clock),
      .load            (stage_ready[ST_TC:0]),
      .cal             (cal_ff),
      .raw_temperature (req_raw_temperature),
      .raw_humidity    (req_raw_humidity),
      .tc              (tc),
      .hum_raw         (hum_raw)
   );

   sthc_hum u_hum (
      .clock      (clock),
      .load       (stage_ready[ST_SCALE:ST_MUL_H]),
      .cal        (cal_ff),
      .tc         (tc),
      .hum_raw    (hum_raw),
      .tc_out     (tc_late),
      .hum_scaled (hum_scaled)
   );

   always_comb begin
      hum_shr = hum_scaled >>> 12;
      if (hum_shr < 0) begin
         hum_in = '0;
      end else if (hum_shr > HUM_MAX) begin
         hum_in = HUM_MAX[HUM_W-1:0];
      end else begin
         hum_in = hum_shr[HUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[ST_OUT]) begin
         temp_ff <= tc_late;
         hum_ff  <= hum_in;
      end
   end

   assign req_stall             = !stage_ready[0];
   assign rsp_valid             = vld_ff[ST_OUT];
   assign rsp_temperature_centi = temp_ff;
   assign rsp_humidity_milli    = hum_ff;

endmodule

// File: dv/sensor_temp_humidity_compensation_core_tb.sv
// ----------------------------------------------------------------------------
// Temperature and humidity compensation core testbench
// Drives raw temperature and humidity readings into the core under several
// calibration settings and checks every result transfer, in order, against a
// predictor of the integer compensation formulas with 32-bit wrapping math.
// Both channels idle at random, and one phase holds the result side off long
// enough to fill the pipeline and stall the request side.
// ----------------------------------------------------------------------------
module sensor_temp_humidity_compensation_core_tb;
   import sthc_pkg::*;

   localparam int DRAIN_CYCLES   = NUM_STAGES + 4;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRESSURE_HOLD  = 300;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_SAMPLES  = 220;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_HIGH = 3'd7;

   typedef struct packed {
      logic [RAW_TEMP_W-1:0] raw_t;
      logic [RAW_HUM_W-1:0]  raw_h;
   } sample_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic [HUM_W-1:0]         hum;
   } reading_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [RAW_TEMP_W-1:0]         req_raw_temperature = '0;
   logic [RAW_HUM_W-1:0]          req_raw_humidity = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [TEMP_W-1:0]      rsp_temperature_centi;
   logic [HUM_W-1:0]              rsp_humidity_milli;
   logic                          csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_data = '0;

   logic [15:0]        cal_t1 = '0;
   logic signed [15:0] cal_t2 = '0;
   logic signed [7:0]  cal_t3 = '0;
   logic [11:0]        cal_h1 = '0;
   logic [11:0]        cal_h2 = '0;
   logic [39:0]        cal_hbytes = '0;

   sample_type  pending_samples[$];
   reading_type expected_readings[$];
   sample_type  next_sample;
   sample_type  taken_sample;
   reading_type wanted;

   bit send_gaps = 1'b1;
   bit recv_gaps = 1'b1;
   bit pressure_on = 1'b0;
   bit req_accepted = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_count = 0;
   int idle_cycles = 0;
   int error_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sensor_temp_humidity_compensation_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_raw_temperature   (req_raw_temperature),
      .req_raw_humidity      (req_raw_humidity),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_milli    (rsp_humidity_milli),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic reading_type compensate(sample_type s);
      int adc_t, adc_h, t1, t2, t3, h1, h2, h3, h4, h5, h6, h7;
      int a, b, c, fine, tc, v1, v2, v3, v4, v5, v6, hum;
      reading_type r;
      adc_t = {12'd0, s.raw_t};
      adc_h = {16'd0, s.raw_h};
      t1 = {16'd0, cal_t1};
      t2 = {{16{cal_t2[15]}}, cal_t2};
      t3 = {{24{cal_t3[7]}}, cal_t3};
      h1 = {20'd0, cal_h1};
      h2 = {20'd0, cal_h2};
      h3 = {{24{cal_hbytes[7]}}, cal_hbytes[7:0]};
      h4 = {{24{cal_hbytes[15]}}, cal_hbytes[15:8]};
      h5 = {{24{cal_hbytes[23]}}, cal_hbytes[23:16]};
      h6 = {24'd0, cal_hbytes[31:24]};
      h7 = {{24{cal_hbytes[39]}}, cal_hbytes[39:32]};

      a = (adc_t >>> 3) - (t1 <<< 1);
      b = (a * t2) >>> 11;
      c = ((((a >>> 1) * (a >>> 1)) >>> 12) * (t3 <<< 4)) >>> 14;
      fine = b + c;
      tc = (fine * 5 + 128) >>> 8;
      if (tc > 32767) r.temp = 16'sh7FFF;
      else if (tc < -32768) r.temp = 16'sh8000;
      else r.temp = tc[15:0];

      v1 = adc_h - (h1 <<< 4) - (((tc * h3) / 100) >>> 1);
      v2 = (tc * h4) / 100 + (((tc * ((tc * h5) / 100)) >>> 6) / 100);
      v2 = (h2 * (v2 + 16384)) >>> 10;
      v3 = v1 * v2;
      v4 = ((h6 <<< 7) + ((tc * h7) / 100)) >>> 4;
      v5 = ((v3 >>> 14) * (v3 >>> 14)) >>> 10;
      v6 = (v4 * v5) >>> 1;
      hum = (((v3 + v6) >>> 10) * 1000) >>> 12;
      if (hum < 0) hum = 0;
      else if (hum > 100000) hum = 100000;
      r.hum = hum[HUM_W-1:0];
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_cal_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return w[CSR_DATA_W-1:0];
      endcase
   endfunction

   task automatic write_csr(logic [CSR_INDEX_W-1:0] reg_index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= reg_index;
      csr_data <= data;
      case (reg_index)
         REG_TEMP_CAL_ONE:   cal_t1 = data[15:0];
         REG_TEMP_CAL_TWO:   cal_t2 = data[15:0];
         REG_TEMP_CAL_THREE: cal_t3 = data[7:0];
         REG_HUM_CAL_ONE:    cal_h1 = data[11:0];
         REG_HUM_CAL_TWO:    cal_h2 = data[11:0];
         REG_HUM_CAL_BYTES:  cal_hbytes = data[39:0];
         default: ;
      endcase
   endtask

   task automatic end_csr_writes();
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic program_cal(logic [CSR_DATA_W-1:0] t1, logic [CSR_DATA_W-1:0] t2,
                              logic [CSR_DATA_W-1:0] t3, logic [CSR_DATA_W-1:0] h1,
                              logic [CSR_DATA_W-1:0] h2, logic [CSR_DATA_W-1:0] hb);
      write_csr(REG_TEMP_CAL_ONE, t1);
      write_csr(REG_TEMP_CAL_TWO, t2);
      write_csr(REG_TEMP_CAL_THREE, t3);
      write_csr(REG_HUM_CAL_ONE, h1);
      write_csr(REG_HUM_CAL_TWO, h2);
      write_csr(REG_HUM_CAL_BYTES, hb);
      end_csr_writes();
   endtask

   task automatic add_sample(logic [RAW_TEMP_W-1:0] t, logic [RAW_HUM_W-1:0] h);
      sample_type s;
      s.raw_t = t;
      s.raw_h = h;
      pending_samples.push_back(s);
   endtask

   task automatic add_corner_samples();
      add_sample(20'h00000, 16'h0000);
      add_sample(20'hFFFFF, 16'hFFFF);
      add_sample(20'hFFFFF, 16'h0000);
      add_sample(20'h00000, 16'hFFFF);
   endtask

   task automatic add_random_samples(int count);
      logic [31:0]           word_t;
      logic [31:0]           word_h;
      logic [RAW_TEMP_W-1:0] t;
      logic [RAW_HUM_W-1:0]  h;
      for (int i = 0; i < count; i++) begin
         word_t = $urandom;
         word_h = $urandom;
         t = word_t[RAW_TEMP_W-1:0];
         h = word_h[RAW_HUM_W-1:0];
         if ($urandom_range(0, 15) == 0) t = {RAW_TEMP_W{word_t[31]}};
         if ($urandom_range(0, 15) == 0) h = {RAW_HUM_W{word_h[31]}};
         add_sample(t, h);
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_readings.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_accepted)) begin
         if (req_accepted) send_gap = send_gaps ? next_gap() : 0;
         if (send_gap > 0 || pending_samples.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_valid <= 1'b0;
         end else begin
            next_sample = pending_samples.pop_front();
            req_valid <= 1'b1;
            req_raw_temperature <= next_sample.raw_t;
            req_raw_humidity <= next_sample.raw_h;
         end
      end
   end

   always @(negedge clock) begin
      if (!pressure_on) hold_count = 0;
      if (pressure_on && hold_count < PRESSURE_HOLD) begin
         hold_count++;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = recv_gaps ? next_gap() : 0;
      end
   end

   always @(posedge clock) begin
      req_accepted = req_valid && !req_stall;
      if (req_accepted) begin
         taken_sample.raw_t = req_raw_temperature;
         taken_sample.raw_h = req_raw_humidity;
         expected_readings.push_back(compensate(taken_sample));
      end
      if (rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("Unexpected result transfer: temperature %0d, humidity %0d",
                        rsp_temperature_centi, rsp_humidity_milli);
         end else begin
            wanted = expected_readings.pop_front();
            if (rsp_temperature_centi !== wanted.temp || rsp_humidity_milli !== wanted.hum) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("Mismatch: temperature %0d (expected %0d), humidity %0d (expected %0d)",
                           rsp_temperature_centi, wanted.temp, rsp_humidity_milli, wanted.hum);
            end
         end
      end
      if (req_accepted || (rsp_valid && !rsp_stall) ||
          (pending_samples.size() == 0 && !req_valid && expected_readings.size() == 0))
         idle_cycles = 0;
      else
         idle_cycles++;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      add_corner_samples();
      drain();

      program_cal(40'd26100, 40'd26400, 40'd3, 40'd700, 40'd1000, 40'h9C_78_14_2D_00);
      add_corner_samples();
      add_sample(20'hAAAAA, 16'h5555);
      add_sample(20'h55555, 16'hAAAA);
      add_sample(20'd500000, 16'd25000);
      add_sample(20'd420000, 16'd45000);
      add_sample(20'd600000, 16'd12000);
      drain();

      write_csr(REG_UNUSED_LOW, '1);
      write_csr(REG_UNUSED_HIGH, '1);
      end_csr_writes();
      add_sample(20'd500000, 16'd30000);
      add_sample(20'd520000, 16'd60000);
      drain();

      program_cal(40'hFFFF, 40'h7FFF, 40'h7F, 40'hFFF, 40'hFFF, 40'h7F_FF_7F_7F_7F);
      add_corner_samples();
      drain();

      program_cal(40'h0, 40'h8000, 40'h80, 40'h0, 40'h0, 40'h80_00_80_80_80);
      add_corner_samples();
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         program_cal(random_cal_word(), random_cal_word(), random_cal_word(),
                     random_cal_word(), random_cal_word(), random_cal_word());
         send_gaps = (p != 2) && (p != 5);
         recv_gaps = (p != 2);
         pressure_on = (p == 5);
         add_random_samples(PHASE_SAMPLES);
         drain();
      end
      pressure_on = 1'b0;

      if (error_count == 0 && expected_readings.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
